// ----- hw/rtl/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Screen geometry, field widths, request codes and cell helpers.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 24;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CELL_W  = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    localparam logic [3:0] RESET_FORE = 4'd7;
    localparam logic [3:0] RESET_BACK = 4'd0;

    localparam logic [2:0] REQ_PUT   = 3'd0;
    localparam logic [2:0] REQ_BS    = 3'd1;
    localparam logic [2:0] REQ_BBS   = 3'd2;
    localparam logic [2:0] REQ_GOTO  = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;
    localparam logic [2:0] REQ_READ  = 3'd5;

    localparam logic REG_FORE = 1'b0;
    localparam logic REG_BACK = 1'b1;

    typedef logic [CELL_W-1:0] t_cell;

    function automatic t_cell make_cell(logic [7:0] ch, logic [3:0] fore, logic [3:0] back);
        return {back, fore, ch};
    endfunction

endpackage

// ----- hw/rtl/tcce_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Carries one request word from a source to a sink with valid and ready.
// ----------------------------------------------------------------------------
interface tcce_req_if
    import tcce_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [2:0]       req_type;
    logic [7:0]       char_code;
    logic [COL_W-1:0] pos_col;
    logic [ROW_W-1:0] pos_row;
    logic [COL_W-1:0] limit_col;
    logic [3:0]       wipe_fore;
    logic [3:0]       wipe_back;

    modport source (
        output valid, req_type, char_code, pos_col, pos_row, limit_col, wipe_fore,
               wipe_back,
        input  ready
    );

    modport sink (
        input  valid, req_type, char_code, pos_col, pos_row, limit_col, wipe_fore,
               wipe_back,
        output ready
    );
endinterface

// ----- hw/rtl/tcce_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Carries one result word from a source to a sink with valid and ready.
// ----------------------------------------------------------------------------
interface tcce_rsp_if
    import tcce_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    t_cell            cell_value;
    logic             did_scroll;

    modport source (
        output valid, cursor_col, cursor_row, cell_value, did_scroll,
        input  ready
    );

    modport sink (
        input  valid, cursor_col, cursor_row, cell_value, did_scroll,
        output ready
    );
endinterface

// ----- hw/rtl/text_console_cursor_engine_top.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine
// Screen cell store with cursor, deferred wrap, backspace, goto, scroll, clear and cell read.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Word
//  i_req     in         valid/ready               one request
//  o_rsp     out        valid/ready               cursor, cell, scroll flag
//  APB       in/out     psel/penable, pready=1    color registers
//
//  A printable put, a backspace that blanks a cell and an in-range read pass
//  through S_WRITE or S_READ between S_EXEC and S_DONE; every other request
//  skips both. A scroll adds a sweep that blanks the new bottom row, a clear
//  a sweep that blanks every cell, both through the single write port of the
//  cell memory. Scrolling rotates a top row pointer instead of moving cells.
//  After reset a clearing pass over every cell runs before the first request
//  is taken. A new request is taken while a finished result waits in the
//  output register.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top
    import tcce_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    tcce_req_if.sink           i_req,
    tcce_rsp_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state;
    logic [2:0]        r_after;
    logic [3:0]        r_fore;
    logic [3:0]        r_back;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  r_top;
    logic [ADDR_W-1:0] r_sweep_addr;
    logic [ADDR_W-1:0] r_sweep_left;
    t_cell             r_fill;
    t_cell             r_wdata;
    logic              r_advance;
    logic              r_scrolled;
    t_cell             r_cell;
    t_cell             r_rdata;
    logic              r_out_valid;
    logic [COL_W-1:0]  r_o_col;
    logic [ROW_W-1:0]  r_o_row;
    t_cell             r_o_cell;
    logic              r_o_scroll;

    logic [2:0]        r_req_type;
    logic [7:0]        r_char;
    logic [COL_W-1:0]  r_pcol;
    logic [ROW_W-1:0]  r_prow;
    logic [COL_W-1:0]  r_limit;
    logic [3:0]        r_wfore;
    logic [3:0]        r_wback;

    t_cell             r_mem [CELLS];

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_cell             mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              read_in_range;
    logic [ROW_W-1:0]  top_next;
    t_cell             blank_cell;

    function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                     logic [COL_W-1:0] col,
                                                     logic [ROW_W-1:0] top);
        logic [ROW_W:0] phys;
        phys = {1'b0, row} + {1'b0, top};
        if (phys >= (ROW_W+1)'(ROWS)) begin
            phys = phys - (ROW_W+1)'(ROWS);
        end
        return ADDR_W'(phys * COLUMNS) + ADDR_W'(col);
    endfunction

    assign read_in_range = (r_prow < ROW_W'(ROWS)) && (r_pcol < COL_W'(COLUMNS));
    assign top_next      = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + 1'b1;
    assign blank_cell    = make_cell(SPACE_CODE, r_fore, r_back);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sweep_addr;
        mem_wdata = r_fill;
        if (r_state == S_SWEEP) begin
            mem_we = 1'b1;
        end else if (r_state == S_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(r_row, r_col, r_top);
            mem_wdata = r_wdata;
        end
    end

    assign mem_re    = (r_state == S_EXEC) && (r_req_type == REQ_READ) && read_in_range;
    assign mem_raddr = cell_addr(r_prow, r_pcol, r_top);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_type <= i_req.req_type;
            r_char     <= i_req.char_code;
            r_pcol     <= i_req.pos_col;
            r_prow     <= i_req.pos_row;
            r_limit    <= i_req.limit_col;
            r_wfore    <= i_req.wipe_fore;
            r_wback    <= i_req.wipe_back;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_after      <= S_IDLE;
            r_fore       <= RESET_FORE;
            r_back       <= RESET_BACK;
            r_col        <= '0;
            r_row        <= '0;
            r_top        <= '0;
            r_sweep_addr <= '0;
            r_sweep_left <= ADDR_W'(CELLS - 1);
            r_fill       <= make_cell(SPACE_CODE, RESET_FORE, RESET_BACK);
            r_out_valid  <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_FORE) begin
                    r_fore <= pwdata[3:0];
                end else begin
                    r_back <= pwdata[3:0];
                end
            end

            if (r_out_valid && o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_scrolled <= 1'b0;
                        r_cell     <= '0;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_req_type)
                        REQ_PUT: begin
                            r_wdata   <= make_cell(r_char, r_fore, r_back);
                            r_advance <= 1'b1;
                            if (r_char == NEWLINE_CODE || r_col >= COL_W'(COLUMNS)) begin
                                r_col <= '0;
                                if (r_row >= ROW_W'(ROWS - 1)) begin
                                    r_row        <= ROW_W'(ROWS - 1);
                                    r_top        <= top_next;
                                    r_sweep_addr <= ADDR_W'(r_top * COLUMNS);
                                    r_sweep_left <= ADDR_W'(COLUMNS - 1);
                                    r_fill       <= blank_cell;
                                    r_scrolled   <= 1'b1;
                                    r_after      <= (r_char == NEWLINE_CODE) ? S_DONE
                                                                             : S_WRITE;
                                    r_state      <= S_SWEEP;
                                end else begin
                                    r_row   <= r_row + 1'b1;
                                    r_state <= (r_char == NEWLINE_CODE) ? S_DONE : S_WRITE;
                                end
                            end else begin
                                r_state <= S_WRITE;
                            end
                        end
                        REQ_BS: begin
                            r_wdata   <= blank_cell;
                            r_advance <= 1'b0;
                            if (r_col != '0) begin
                                r_col   <= r_col - 1'b1;
                                r_state <= S_WRITE;
                            end else if (r_row != '0) begin
                                r_row   <= r_row - 1'b1;
                                r_col   <= COL_W'(COLUMNS - 1);
                                r_state <= S_WRITE;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        REQ_BBS: begin
                            r_wdata   <= blank_cell;
                            r_advance <= 1'b0;
                            if (r_col > r_limit) begin
                                r_col   <= r_col - 1'b1;
                                r_state <= S_WRITE;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        REQ_GOTO: begin
                            r_col   <= (r_pcol > COL_W'(COLUMNS)) ? COL_W'(COLUMNS) : r_pcol;
                            r_row   <= (r_prow > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                                   : r_prow;
                            r_state <= S_DONE;
                        end
                        REQ_CLEAR: begin
                            r_col        <= '0;
                            r_row        <= '0;
                            r_top        <= '0;
                            r_sweep_addr <= '0;
                            r_sweep_left <= ADDR_W'(CELLS - 1);
                            r_fill       <= make_cell(SPACE_CODE, r_wfore, r_wback);
                            r_after      <= S_DONE;
                            r_state      <= S_SWEEP;
                        end
                        REQ_READ: begin
                            r_state <= read_in_range ? S_READ : S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_SWEEP: begin
                    r_sweep_addr <= r_sweep_addr + 1'b1;
                    r_sweep_left <= r_sweep_left - 1'b1;
                    if (r_sweep_left == '0) begin
                        r_state <= r_after;
                    end
                end
                S_WRITE: begin
                    if (r_advance) begin
                        r_col <= r_col + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_READ: begin
                    r_cell  <= r_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_o_col     <= r_col;
                        r_o_row     <= r_row;
                        r_o_cell    <= r_cell;
                        r_o_scroll  <= r_scrolled;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cursor_col = r_o_col;
    assign o_rsp.cursor_row = r_o_row;
    assign o_rsp.cell_value = r_o_cell;
    assign o_rsp.did_scroll = r_o_scroll;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BACK) ? PDATA_W'(r_back) : PDATA_W'(r_fore);

`ifndef ASSERT_OFF
    a_row_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row < ROW_W'(ROWS) && r_top < ROW_W'(ROWS))
        else $error("cursor row or top row pointer outside the screen");

    a_col_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(COLUMNS))
        else $error("cursor column beyond the wrap position");

    a_write_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> r_col < COL_W'(COLUMNS))
        else $error("cell write with the cursor at the wrap position");

    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.did_scroll |->
            o_rsp.cursor_row == ROW_W'(ROWS - 1) && o_rsp.cursor_col <= COL_W'(1))
        else $error("scroll reported without the cursor at the start of the bottom row");
`endif

endmodule
